// ===== rtl/edc_pkg.sv =====
// ============================================================================
// edc_pkg: shared definitions for the expiring decision cache
// Sizes, operation and status codes, transfer payload types, the cache entry
// layout and the per-hook counter interface.
// ============================================================================
package edc_pkg;

    localparam int ENTRIES_PER_HOOK = 256;
    localparam int HOOK_TYPES       = 8;

    localparam int SLOTS    = ENTRIES_PER_HOOK * HOOK_TYPES;
    localparam int IDX_W    = $clog2(ENTRIES_PER_HOOK);
    localparam int HOOK_W   = (HOOK_TYPES > 1) ? $clog2(HOOK_TYPES) : 1;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam bit IDX_POW2 = ((ENTRIES_PER_HOOK & (ENTRIES_PER_HOOK - 1)) == 0);
    localparam logic [31:0] IDX_RECIP = 32'((64'd1 << 32) / ENTRIES_PER_HOOK);

    localparam logic [1:0] OP_LOOKUP     = 2'd0;
    localparam logic [1:0] OP_INSERT     = 2'd1;
    localparam logic [1:0] OP_INVALIDATE = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FALLBACK    = 2'd1;
    localparam logic [1:0] ST_BAD_HOOK    = 2'd2;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  hook_sel;
        logic [31:0] ctx_key;
        logic        cache_en;
        logic [63:0] now_time;
        logic [31:0] new_verdict_id;
        logic [7:0]  new_confidence;
        logic        new_cache_flag;
        logic [63:0] new_expiry;
    } edc_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] verdict_id;
        logic [7:0]  confidence;
        logic        cache_flag;
        logic [63:0] expiry_out;
        logic [31:0] requested_count;
        logic [31:0] hit_count;
        logic [31:0] fallback_count;
    } edc_out_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] verdict_id;
        logic [7:0]  confidence;
        logic        cache_flag;
        logic [63:0] expiry;
    } edc_entry_t;

    localparam int ENTRY_W = $bits(edc_entry_t);

    typedef struct packed {
        logic commit;
        logic req;
        logic hit;
        logic fb;
    } edc_cnt_upd_t;

    typedef struct packed {
        logic [31:0] req;
        logic [31:0] hit;
        logic [31:0] fb;
    } edc_cnt_t;

    function automatic logic [SLOT_W-1:0] slot_base(input logic [HOOK_W-1:0] hook);
        return SLOT_W'(hook) * SLOT_W'(ENTRIES_PER_HOOK);
    endfunction

endpackage

// ===== rtl/edc_ram.sv =====
// ============================================================================
// edc_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ============================================================================
module edc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/edc_slot.sv =====
// ============================================================================
// edc_slot: cache slot computation
// Maps a hook type and context id to a slot: the hook's base plus the
// context id modulo the entry count, by masking or by reciprocal multiply.
// ============================================================================
module edc_slot (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [31:0]               ctx,
    input  logic [edc_pkg::HOOK_W-1:0] hook,
    output logic                      done,
    output logic [edc_pkg::SLOT_W-1:0] slot
);

    generate
        if (edc_pkg::IDX_POW2)
        begin : g_mask
            assign done = start;
            assign slot = edc_pkg::slot_base(hook)
                        + edc_pkg::SLOT_W'(ctx[edc_pkg::IDX_W-1:0]);
        end
        else
        begin : g_recip
            logic                       v1_reg;
            logic                       v2_reg;
            logic [63:0]                prod_reg;
            logic [31:0]                ctx1_reg;
            logic [31:0]                ctx2_reg;
            logic [31:0]                qe_reg;
            logic [edc_pkg::HOOK_W-1:0] hook1_reg;
            logic [edc_pkg::HOOK_W-1:0] hook2_reg;
            logic [31:0]                diff;
            logic [edc_pkg::IDX_W-1:0]  rem;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v1_reg <= 1'b0;
                    v2_reg <= 1'b0;
                end
                else
                begin
                    v1_reg <= start;
                    v2_reg <= v1_reg;
                end
            end

            // The quotient estimate is low by at most one, so one correction
            // step brings the remainder into range.
            always_ff @(posedge clk)
            begin
                prod_reg  <= 64'(ctx) * 64'(edc_pkg::IDX_RECIP);
                ctx1_reg  <= ctx;
                hook1_reg <= hook;
                qe_reg    <= prod_reg[63:32] * 32'(edc_pkg::ENTRIES_PER_HOOK);
                ctx2_reg  <= ctx1_reg;
                hook2_reg <= hook1_reg;
            end

            always_comb
            begin
                diff = ctx2_reg - qe_reg;
                if (diff >= 32'(edc_pkg::ENTRIES_PER_HOOK))
                begin
                    rem = edc_pkg::IDX_W'(diff - 32'(edc_pkg::ENTRIES_PER_HOOK));
                end
                else
                begin
                    rem = edc_pkg::IDX_W'(diff);
                end
            end

            assign done = v2_reg;
            assign slot = edc_pkg::slot_base(hook2_reg) + edc_pkg::SLOT_W'(rem);
        end
    endgenerate

endmodule

// ===== rtl/edc_stats.sv =====
// ============================================================================
// edc_stats: per-hook request, hit and fallback counters
// Presents the counts of one hook after the pending update and commits them.
// ============================================================================
module edc_stats (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [edc_pkg::HOOK_W-1:0] hook,
    input  edc_pkg::edc_cnt_upd_t      upd,
    output edc_pkg::edc_cnt_t          counts
);

    logic [31:0] req_cnt_reg [edc_pkg::HOOK_TYPES];
    logic [31:0] hit_cnt_reg [edc_pkg::HOOK_TYPES];
    logic [31:0] fb_cnt_reg  [edc_pkg::HOOK_TYPES];

    always_comb
    begin
        counts.req = req_cnt_reg[hook] + 32'(upd.req);
        counts.hit = hit_cnt_reg[hook] + 32'(upd.hit);
        counts.fb  = fb_cnt_reg[hook] + 32'(upd.fb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < edc_pkg::HOOK_TYPES; i++)
            begin
                req_cnt_reg[i] <= '0;
                hit_cnt_reg[i] <= '0;
                fb_cnt_reg[i]  <= '0;
            end
        end
        else if (upd.commit)
        begin
            req_cnt_reg[hook] <= counts.req;
            hit_cnt_reg[hook] <= counts.hit;
            fb_cnt_reg[hook]  <= counts.fb;
        end
    end

endmodule

// ===== rtl/expiring_decision_cache.sv =====
// ============================================================================
// expiring_decision_cache: direct-mapped decision cache with expiry
// Per-hook caches in a valid-bit RAM and an entry RAM, with per-hook counters.
// ============================================================================
// After reset the block clears the valid-bit RAM, one entry per cycle, over all
// SLOTS entries (2048 with the default sizes) and takes no input transfer in
// that time. A lookup or insert that uses the cache first reads or writes the
// RAMs and then, in S_FINISH, does the tag and expiry check and the counter
// update; its result is registered once the output register is free. When the
// entry count is not a power of two, the slot index first comes from a
// two-stage reciprocal multiply. An invalidate clears the hook's valid bits
// one per cycle. Items are handled one at a time; a
// finished result waits in an output register while the next item is taken.
// ============================================================================
module expiring_decision_cache (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  edc_pkg::edc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output edc_pkg::edc_out_t out_data
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_INDEX  = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [edc_pkg::SLOT_W-1:0] sweep_cnt_reg;
    logic [edc_pkg::SLOT_W-1:0] sweep_cnt_next;
    edc_pkg::edc_in_t           item_reg;
    logic                       en_reg;
    logic                       out_valid_reg;
    edc_pkg::edc_out_t          out_data_reg;

    edc_pkg::edc_in_t           cur;
    logic                       cur_hook_ok;
    logic                       cur_needs_slot;
    logic                       in_fire;
    logic                       slot_start;
    logic                       slot_done;
    logic [edc_pkg::SLOT_W-1:0] slot;
    logic                       acc_lookup;
    logic                       acc_insert;
    logic                       clear_last;
    logic                       sweep_last;

    logic                       vld_we;
    logic [edc_pkg::SLOT_W-1:0] vld_waddr;
    logic                       vld_wdata;
    logic                       vld_rdata;
    edc_pkg::edc_entry_t        ent_wdata;
    edc_pkg::edc_entry_t        ent_rdata;

    logic                       item_hook_ok;
    logic                       lookup_ok;
    logic                       hit;
    logic                       fin_fire;
    edc_pkg::edc_cnt_upd_t      cnt_upd;
    edc_pkg::edc_cnt_t          counts;
    edc_pkg::edc_out_t          res;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Access fields come straight from the port in the transfer cycle.
    always_comb
    begin
        cur            = (state_reg == S_IDLE) ? in_data : item_reg;
        cur_hook_ok    = ({1'b0, cur.hook_sel} < 5'(edc_pkg::HOOK_TYPES));
        cur_needs_slot = cur_hook_ok
                       && (((cur.opcode == edc_pkg::OP_LOOKUP) && en_reg && cur.cache_en)
                        || ((cur.opcode == edc_pkg::OP_INSERT) && cur.new_cache_flag));
        slot_start     = in_fire && cur_needs_slot;
        acc_lookup     = slot_done && (cur.opcode == edc_pkg::OP_LOOKUP);
        acc_insert     = slot_done && (cur.opcode == edc_pkg::OP_INSERT);
        clear_last     = (sweep_cnt_reg == edc_pkg::SLOT_W'(edc_pkg::SLOTS - 1));
        sweep_last     = (sweep_cnt_reg == edc_pkg::SLOT_W'(edc_pkg::ENTRIES_PER_HOOK - 1));
    end

    edc_slot u_slot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (slot_start),
        .ctx   (cur.ctx_key),
        .hook  (cur.hook_sel[edc_pkg::HOOK_W-1:0]),
        .done  (slot_done),
        .slot  (slot)
    );

    always_comb
    begin
        priority if (state_reg == S_CLEAR)
        begin
            vld_we    = 1'b1;
            vld_waddr = sweep_cnt_reg;
            vld_wdata = 1'b0;
        end
        else if (state_reg == S_SWEEP)
        begin
            vld_we    = 1'b1;
            vld_waddr = edc_pkg::slot_base(item_reg.hook_sel[edc_pkg::HOOK_W-1:0])
                      + sweep_cnt_reg;
            vld_wdata = 1'b0;
        end
        else
        begin
            vld_we    = acc_insert;
            vld_waddr = slot;
            vld_wdata = 1'b1;
        end
    end

    always_comb
    begin
        ent_wdata.tag        = cur.ctx_key;
        ent_wdata.verdict_id = cur.new_verdict_id;
        ent_wdata.confidence = cur.new_confidence;
        ent_wdata.cache_flag = 1'b1;
        ent_wdata.expiry     = cur.new_expiry;
    end

    edc_ram #(
        .WIDTH (1),
        .DEPTH (edc_pkg::SLOTS)
    ) u_valid_ram (
        .clk   (clk),
        .we    (vld_we),
        .waddr (vld_waddr),
        .wdata (vld_wdata),
        .re    (acc_lookup),
        .raddr (slot),
        .rdata (vld_rdata)
    );

    edc_ram #(
        .WIDTH (edc_pkg::ENTRY_W),
        .DEPTH (edc_pkg::SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (acc_insert),
        .waddr (slot),
        .wdata (ent_wdata),
        .re    (acc_lookup),
        .raddr (slot),
        .rdata (ent_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                sweep_cnt_next = '0;
                if (in_fire)
                begin
                    priority if (cur_needs_slot)
                    begin
                        state_next = slot_done ? S_FINISH : S_INDEX;
                    end
                    else if ((cur.opcode == edc_pkg::OP_INVALIDATE) && cur_hook_ok)
                    begin
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_INDEX:
            begin
                if (slot_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (fin_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next     = S_CLEAR;
                sweep_cnt_next = '0;
            end
        endcase
    end

    assign fin_fire = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        item_hook_ok   = ({1'b0, item_reg.hook_sel} < 5'(edc_pkg::HOOK_TYPES));
        lookup_ok      = (item_reg.opcode == edc_pkg::OP_LOOKUP) && en_reg && item_hook_ok;
        hit            = lookup_ok && item_reg.cache_en && vld_rdata
                       && (ent_rdata.tag == item_reg.ctx_key)
                       && (item_reg.now_time < ent_rdata.expiry);
        cnt_upd.commit = fin_fire && lookup_ok;
        cnt_upd.req    = lookup_ok;
        cnt_upd.hit    = hit;
        cnt_upd.fb     = lookup_ok && !hit;
    end

    edc_stats u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .hook   (item_reg.hook_sel[edc_pkg::HOOK_W-1:0]),
        .upd    (cnt_upd),
        .counts (counts)
    );

    always_comb
    begin
        res = '0;
        priority if (item_reg.opcode == edc_pkg::OP_LOOKUP)
        begin
            priority if (!en_reg)
            begin
                res.status = edc_pkg::ST_UNSUPPORTED;
            end
            else if (!item_hook_ok)
            begin
                res.status = edc_pkg::ST_BAD_HOOK;
            end
            else if (hit)
            begin
                res.status = edc_pkg::ST_OK;
            end
            else
            begin
                res.status = edc_pkg::ST_FALLBACK;
            end
        end
        else if ((item_reg.opcode == edc_pkg::OP_INSERT)
              || (item_reg.opcode == edc_pkg::OP_INVALIDATE))
        begin
            res.status = item_hook_ok ? edc_pkg::ST_OK : edc_pkg::ST_BAD_HOOK;
        end
        else
        begin
            res.status = edc_pkg::ST_UNSUPPORTED;
        end
        if (hit)
        begin
            res.verdict_id = ent_rdata.verdict_id;
            res.confidence = ent_rdata.confidence;
            res.cache_flag = ent_rdata.cache_flag;
            res.expiry_out = ent_rdata.expiry;
        end
        if (item_hook_ok)
        begin
            res.requested_count = counts.req;
            res.hit_count       = counts.hit;
            res.fallback_count  = counts.fb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_cnt_reg <= '0;
            en_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            if (cfg_wr_en)
            begin
                en_reg <= cfg_wr_data;
            end
            out_valid_reg <= fin_fire || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        if (fin_fire)
        begin
            out_data_reg <= res;
        end
    end

endmodule

// ===== rtl/edc_checker.sv =====
// ============================================================================
// edc_checker: port-level checks for the expiring decision cache
// Watches the top-level ports and is attached to every instance by bind.
// ============================================================================
module edc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input edc_pkg::edc_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Result changed or dropped while stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input taken while an item is still in work.");

    a_fallback_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == edc_pkg::ST_FALLBACK)
        |-> (out_data.verdict_id == '0) && (out_data.confidence == '0)
            && (out_data.cache_flag == 1'b0) && (out_data.expiry_out == '0))
        else $error("Fallback result carries decision data.");

    a_bad_hook_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == edc_pkg::ST_BAD_HOOK)
        |-> (out_data.requested_count == '0) && (out_data.hit_count == '0)
            && (out_data.fallback_count == '0))
        else $error("Invalid hook result reports counters.");

endmodule

bind expiring_decision_cache edc_checker u_edc_checker (.*);

// ===== verif/tb_expiring_decision_cache.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_expiring_decision_cache: self-checking testbench for the decision cache
// A short table of directed requests covers reset behavior, field extremes,
// disabled lookups, bad hooks, stale entries, ignored inserts and invalidates.
// Random traffic follows, biased toward a small set of context ids and a
// narrow time window so that hits, stale entries and index conflicts are
// common. Results are checked against the table's or a behavioral model's.
// ============================================================================
module tb_expiring_decision_cache;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int    STALL_LIMIT      = 20000;
    localparam int    HOLD_CYCLES      = 400;
    localparam int    SETTLE_CYCLES    = 4;
    localparam int    DRAIN_CYCLES     = 20;
    localparam int    IDLE_PERCENT     = 37;
    localparam logic [3:0] PHASE_ENABLE = 4'b1101;
    localparam edc_pkg::edc_out_t NO_RESULT = '0;

    typedef struct {
        bit                cfg_write;
        bit                cfg_value;
        edc_pkg::edc_in_t  item;
        bit                typed;
        edc_pkg::edc_out_t result;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic              cfg_wr_data;
    logic              in_valid;
    logic              in_ready;
    edc_pkg::edc_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    edc_pkg::edc_out_t out_data;

    bit          line_valid [edc_pkg::SLOTS];
    logic [31:0] line_tag [edc_pkg::SLOTS];
    logic [31:0] line_id [edc_pkg::SLOTS];
    logic [7:0]  line_conf [edc_pkg::SLOTS];
    logic        line_flag [edc_pkg::SLOTS];
    logic [63:0] line_expiry [edc_pkg::SLOTS];
    logic [31:0] lookups_seen [edc_pkg::HOOK_TYPES];
    logic [31:0] hits_seen [edc_pkg::HOOK_TYPES];
    logic [31:0] fallbacks_seen [edc_pkg::HOOK_TYPES];
    bit          lookups_enabled;

    edc_pkg::edc_out_t pending_decisions[$];
    edc_pkg::edc_out_t oldest;
    stim_row_t         plan[$];
    logic [31:0]       ctx_pool [16];
    logic [63:0]       time_base;
    int                errors;
    int                stall_cycles;
    bit                calm;
    bit                hold_outputs;

    expiring_decision_cache uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    always #5 clk = ~clk;

    function automatic edc_pkg::edc_out_t predict_decision(input edc_pkg::edc_in_t it);
        edc_pkg::edc_out_t r;
        bit                hook_ok;
        int                h;
        int                slot;
        r       = '0;
        h       = int'(it.hook_sel);
        hook_ok = h < edc_pkg::HOOK_TYPES;
        slot    = h * edc_pkg::ENTRIES_PER_HOOK
                + int'(it.ctx_key % $unsigned(edc_pkg::ENTRIES_PER_HOOK));
        case (it.opcode)
            edc_pkg::OP_LOOKUP:
            begin
                if (!lookups_enabled)
                begin
                    r.status = edc_pkg::ST_UNSUPPORTED;
                end
                else if (!hook_ok)
                begin
                    r.status = edc_pkg::ST_BAD_HOOK;
                end
                else
                begin
                    lookups_seen[h] = lookups_seen[h] + 1;
                    if (it.cache_en && line_valid[slot]
                        && line_tag[slot] == it.ctx_key
                        && it.now_time < line_expiry[slot])
                    begin
                        r.status     = edc_pkg::ST_OK;
                        r.verdict_id = line_id[slot];
                        r.confidence = line_conf[slot];
                        r.cache_flag = line_flag[slot];
                        r.expiry_out = line_expiry[slot];
                        hits_seen[h] = hits_seen[h] + 1;
                    end
                    else
                    begin
                        r.status          = edc_pkg::ST_FALLBACK;
                        fallbacks_seen[h] = fallbacks_seen[h] + 1;
                    end
                end
            end
            edc_pkg::OP_INSERT:
            begin
                if (!hook_ok)
                begin
                    r.status = edc_pkg::ST_BAD_HOOK;
                end
                else
                begin
                    if (it.new_cache_flag)
                    begin
                        line_valid[slot]  = 1'b1;
                        line_tag[slot]    = it.ctx_key;
                        line_id[slot]     = it.new_verdict_id;
                        line_conf[slot]   = it.new_confidence;
                        line_flag[slot]   = 1'b1;
                        line_expiry[slot] = it.new_expiry;
                    end
                    r.status = edc_pkg::ST_OK;
                end
            end
            edc_pkg::OP_INVALIDATE:
            begin
                if (!hook_ok)
                begin
                    r.status = edc_pkg::ST_BAD_HOOK;
                end
                else
                begin
                    for (int i = 0; i < edc_pkg::ENTRIES_PER_HOOK; i++)
                    begin
                        line_valid[h * edc_pkg::ENTRIES_PER_HOOK + i] = 1'b0;
                    end
                    r.status = edc_pkg::ST_OK;
                end
            end
            default:
            begin
                r.status = edc_pkg::ST_UNSUPPORTED;
            end
        endcase
        if (hook_ok)
        begin
            r.requested_count = lookups_seen[h];
            r.hit_count       = hits_seen[h];
            r.fallback_count  = fallbacks_seen[h];
        end
        return r;
    endfunction

    function automatic edc_pkg::edc_in_t make_request(
        input logic [1:0] op, input logic [3:0] hook, input logic [31:0] ctx,
        input logic use_c, input logic [63:0] now, input logic [31:0] id,
        input logic [7:0] conf, input logic flag, input logic [63:0] expiry);
        edc_pkg::edc_in_t it;
        it.opcode         = op;
        it.hook_sel       = hook;
        it.ctx_key        = ctx;
        it.cache_en       = use_c;
        it.now_time       = now;
        it.new_verdict_id = id;
        it.new_confidence = conf;
        it.new_cache_flag = flag;
        it.new_expiry     = expiry;
        return it;
    endfunction

    function automatic edc_pkg::edc_in_t random_request();
        edc_pkg::edc_in_t it;
        int               pick;
        it.ctx_key        = $urandom;
        it.now_time       = {$urandom, $urandom};
        it.new_verdict_id = $urandom;
        it.new_confidence = 8'($urandom);
        it.new_expiry     = {$urandom, $urandom};
        it.cache_en       = $urandom_range(0, 99) < 85;
        it.new_cache_flag = $urandom_range(0, 99) < 85;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.opcode = edc_pkg::OP_LOOKUP;
        else if (pick < 85)
            it.opcode = edc_pkg::OP_INSERT;
        else if (pick < 90)
            it.opcode = edc_pkg::OP_INVALIDATE;
        else if (pick < 95)
            it.opcode = OP_UNUSED;
        else
            it.opcode = edc_pkg::OP_LOOKUP;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.hook_sel = 4'($urandom_range(0, 3));
        else if (pick < 90)
            it.hook_sel = 4'($urandom_range(0, edc_pkg::HOOK_TYPES - 1));
        else
            it.hook_sel = 4'($urandom_range(edc_pkg::HOOK_TYPES, 15));
        if ($urandom_range(0, 99) < 80)
            it.ctx_key = ctx_pool[$urandom_range(0, 15)];
        if ($urandom_range(0, 99) < 85)
            it.now_time = time_base + 64'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 85)
            it.new_expiry = time_base + 64'($urandom_range(0, 63));
        return it;
    endfunction

    task automatic add_row(input bit cfg_write, input bit cfg_value,
                           input edc_pkg::edc_in_t it, input bit typed,
                           input edc_pkg::edc_out_t res);
        stim_row_t row;
        row.cfg_write = cfg_write;
        row.cfg_value = cfg_value;
        row.item      = it;
        row.typed     = typed;
        row.result    = res;
        plan.push_back(row);
    endtask

    task automatic set_enable(input bit value);
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en       <= 1'b0;
        lookups_enabled = value;
    endtask

    task automatic offer_request(input edc_pkg::edc_in_t it, input bit typed,
                                 input edc_pkg::edc_out_t res);
        int                gap;
        edc_pkg::edc_out_t predicted;
        gap = 0;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
                gap++;
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_decision(it);
        pending_decisions.push_back(typed ? res : predicted);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_outputs)
            begin
                hold_outputs = 1'b0;
                out_ready    <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_decisions.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transfer, expected none, actual %h",
                             $time, out_data);
                end
                else
                begin
                    oldest = pending_decisions.pop_front();
                    check_field("status", oldest.status, out_data.status);
                    check_field("verdict_id", oldest.verdict_id, out_data.verdict_id);
                    check_field("confidence", oldest.confidence, out_data.confidence);
                    check_field("cache_flag", oldest.cache_flag, out_data.cache_flag);
                    check_field("expiry_out", oldest.expiry_out, out_data.expiry_out);
                    check_field("requested_count", oldest.requested_count,
                                out_data.requested_count);
                    check_field("hit_count", oldest.hit_count, out_data.hit_count);
                    check_field("fallback_count", oldest.fallback_count,
                                out_data.fallback_count);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int items;
        errors          = 0;
        stall_cycles    = 0;
        calm            = 1'b0;
        hold_outputs    = 1'b0;
        lookups_enabled = 1'b0;
        for (int i = 0; i < edc_pkg::SLOTS; i++)
        begin
            line_valid[i]  = 1'b0;
            line_tag[i]    = '0;
            line_id[i]     = '0;
            line_conf[i]   = '0;
            line_flag[i]   = 1'b0;
            line_expiry[i] = '0;
        end
        for (int i = 0; i < edc_pkg::HOOK_TYPES; i++)
        begin
            lookups_seen[i]   = '0;
            hits_seen[i]      = '0;
            fallbacks_seen[i] = '0;
        end
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;

        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd0, 32'd0, 1'b1, 64'd0, 32'd0,
                8'd0, 1'b0, 64'd0), 1, '{edc_pkg::ST_UNSUPPORTED, 32'd0, 8'd0, 1'b0, 64'd0,
                32'd0, 32'd0, 32'd0});
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd15, 32'hFFFF_FFFF, 1'b1, 64'd0,
                32'd0, 8'd0, 1'b0, 64'd0), 1, '{edc_pkg::ST_UNSUPPORTED, 32'd0, 8'd0, 1'b0,
                64'd0, 32'd0, 32'd0, 32'd0});
        add_row(0, 0, make_request(edc_pkg::OP_INSERT, 4'd0, 32'd5, 1'b0, 64'd0,
                32'hFFFF_FFFF, 8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF), 1,
                '{edc_pkg::ST_OK, 32'd0, 8'd0, 1'b0, 64'd0, 32'd0, 32'd0, 32'd0});
        add_row(0, 0, make_request(edc_pkg::OP_INSERT, 4'd15, 32'd5, 1'b1, 64'd0, 32'd1,
                8'd1, 1'b1, 64'd9), 1, '{edc_pkg::ST_BAD_HOOK, 32'd0, 8'd0, 1'b0, 64'd0,
                32'd0, 32'd0, 32'd0});
        add_row(0, 0, make_request(OP_UNUSED, 4'd2, 32'd7, 1'b1, 64'd0, 32'd0, 8'd0, 1'b1,
                64'd0), 1, '{edc_pkg::ST_UNSUPPORTED, 32'd0, 8'd0, 1'b0, 64'd0, 32'd0,
                32'd0, 32'd0});
        add_row(1, 1, make_request(edc_pkg::OP_LOOKUP, 4'd0, 32'd5, 1'b1, 64'd0, 32'd0,
                8'd0, 1'b0, 64'd0), 1, '{edc_pkg::ST_OK, 32'hFFFF_FFFF, 8'hFF, 1'b1,
                64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'd1, 32'd0});
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd0, 32'd5, 1'b1,
                64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 8'd0, 1'b0, 64'd0), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd0, 32'd5, 1'b0, 64'd0, 32'd0,
                8'd0, 1'b0, 64'd0), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd0, 32'h105, 1'b1, 64'd0, 32'd0,
                8'd0, 1'b0, 64'd0), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd8, 32'd5, 1'b1, 64'd0, 32'd0,
                8'd0, 1'b0, 64'd0), 1, '{edc_pkg::ST_BAD_HOOK, 32'd0, 8'd0, 1'b0, 64'd0,
                32'd0, 32'd0, 32'd0});
        add_row(0, 0, make_request(edc_pkg::OP_INSERT, 4'd7, 32'hFFFF_FFFF, 1'b1, 64'd0,
                32'd0, 8'd0, 1'b1, 64'd1), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd7, 32'hFFFF_FFFF, 1'b1, 64'd0,
                32'd0, 8'd0, 1'b0, 64'd0), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd7, 32'hFFFF_FFFF, 1'b1, 64'd1,
                32'd0, 8'd0, 1'b0, 64'd0), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_INSERT, 4'd7, 32'hFFFF_FFFF, 1'b1, 64'd0,
                32'h1234_5678, 8'h77, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd7, 32'hFFFF_FFFF, 1'b1, 64'd0,
                32'd0, 8'd0, 1'b0, 64'd0), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_INSERT, 4'd3, 32'h1234_5600, 1'b0, 64'd0,
                32'hA5A5_A5A5, 8'h5A, 1'b1, 64'h8000_0000_0000_0000), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd3, 32'h1234_5600, 1'b1,
                64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 8'd0, 1'b0, 64'd0), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_INVALIDATE, 4'd3, 32'd0, 1'b0, 64'd0, 32'd0,
                8'd0, 1'b0, 64'd0), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd3, 32'h1234_5600, 1'b1, 64'd0,
                32'd0, 8'd0, 1'b0, 64'd0), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd0, 32'd5, 1'b1, 64'd0, 32'd0,
                8'd0, 1'b0, 64'd0), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_INVALIDATE, 4'd9, 32'd0, 1'b0, 64'd0, 32'd0,
                8'd0, 1'b0, 64'd0), 1, '{edc_pkg::ST_BAD_HOOK, 32'd0, 8'd0, 1'b0, 64'd0,
                32'd0, 32'd0, 32'd0});
        add_row(0, 0, make_request(OP_UNUSED, 4'd0, 32'd5, 1'b1, 64'd0, 32'd0, 8'd0, 1'b0,
                64'd0), 0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_INVALIDATE, 4'd0, 32'hFFFF_FFFF, 1'b1,
                64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF),
                0, NO_RESULT);
        add_row(0, 0, make_request(edc_pkg::OP_LOOKUP, 4'd0, 32'd5, 1'b1, 64'd0, 32'd0,
                8'd0, 1'b0, 64'd0), 0, NO_RESULT);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_enable(1'b0);

        foreach (plan[r])
        begin
            if (plan[r].cfg_write)
                set_enable(plan[r].cfg_value);
            offer_request(plan[r].item, plan[r].typed, plan[r].result);
        end

        for (int p = 0; p < 4; p++)
        begin
            set_enable(PHASE_ENABLE[p]);
            for (int i = 0; i < 16; i++)
            begin
                if (i < 8)
                    ctx_pool[i] = $urandom;
                else
                    ctx_pool[i] = ($urandom & 32'hFFFF_FF00) | (ctx_pool[i - 8] & 32'hFF);
            end
            time_base = {$urandom, $urandom};
            items = (p == 1) ? 150 : 600;
            for (int k = 0; k < items; k++)
            begin
                calm = (p == 2) && (k >= 100) && (k < 350);
                if (p == 0 && k == 300)
                    hold_outputs = 1'b1;
                offer_request(random_request(), 1'b0, NO_RESULT);
            end
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_decisions.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
